FILE: hw/rtl/madc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madc_pkg
// Shared types, widths and register codes of the multichannel ADC averager.
// ----------------------------------------------------------------------------
package madc_pkg;

    localparam int CHAN_W    = 4;   // channel field
    localparam int SAMPLE_W  = 12;  // sample field
    localparam int LEVEL_W   = 12;  // average, threshold, hysteresis
    localparam int SUM_W     = 16;  // per-channel accumulator
    localparam int TICK_W    = 8;   // debounce counters
    localparam int SCAN_W    = 4;   // scan counter
    localparam int CFG_IDX_W = 3;

    localparam int NUM_CHANNELS_DEF = 9;
    localparam int AVG_SCANS_DEF    = 10;
    localparam int SAMPLE_BITS_DEF  = 12;

    localparam logic [CFG_IDX_W-1:0] REG_UP_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIG_MASK   = 3'd4;

    localparam logic [TICK_W-1:0]  UP_TICKS_RST   = 8'd20;
    localparam logic [TICK_W-1:0]  DOWN_TICKS_RST = 8'd20;
    localparam logic [LEVEL_W-1:0] THRESHOLD_RST  = 12'd2000;
    localparam logic [LEVEL_W-1:0] HYSTERESIS_RST = 12'd50;

    localparam logic [SUM_W-1:0]   SUM_MAX = '1;
    localparam logic [LEVEL_W-1:0] AVG_MAX = '1;

    // per-channel state word held in the state memory
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic              on;
        logic [TICK_W-1:0] up;
        logic [TICK_W-1:0] down;
    } chan_state_t;

    localparam int ENTRY_W = SUM_W + 1 + 2 * TICK_W;

    typedef struct packed {
        logic [TICK_W-1:0]  up_ticks;
        logic [TICK_W-1:0]  down_ticks;
        logic [LEVEL_W-1:0] threshold;
        logic [LEVEL_W-1:0] hysteresis;
    } cfg_t;

    // one accepted sample on its way into the update stage
    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
        logic                discard;
    } item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  channel;
        logic               is_digital;
        logic [LEVEL_W-1:0] avg;
        logic               on;
    } result_t;

endpackage

FILE: hw/rtl/multichannel_adc_average_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_adc_average_debounce
// Per-channel block averager with threshold, hysteresis and debounce.
// ----------------------------------------------------------------------------
// Takes one ADC sample per clock in scan order. Each channel's running sum and
// debounce state live in one state memory of NUM_CHANNELS words; a sample is
// read from that memory on the transfer edge and modified and written back in
// the next cycle, with the word just written forwarded to a following sample
// of the same channel, so samples of any channel pattern go through at one per
// cycle. After AVG_SCANS accumulating scans, each sample of the next scan
// yields one result for its channel, registered in the update stage and then
// the output register, and clears that sum. Input stalls while the skid entry
// of the two-entry output buffer holds a result, or while a result is pushed
// into a full, stalled output register. Channels at or above NUM_CHANNELS are dropped.
module multichannel_adc_average_debounce #(
    parameter int NUM_CHANNELS = madc_pkg::NUM_CHANNELS_DEF,
    parameter int AVG_SCANS    = madc_pkg::AVG_SCANS_DEF,
    parameter int SAMPLE_BITS  = madc_pkg::SAMPLE_BITS_DEF,
    localparam int CFG_DATA_W  = (NUM_CHANNELS > madc_pkg::LEVEL_W)
                               ? NUM_CHANNELS : madc_pkg::LEVEL_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [madc_pkg::CHAN_W-1:0]     channel,
    input  logic [madc_pkg::SAMPLE_W-1:0]   sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [madc_pkg::CHAN_W-1:0]     out_channel,
    output logic                            is_digital,
    output logic [madc_pkg::LEVEL_W-1:0]    avg_value,
    output logic                            input_on,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [madc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [madc_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
        (SAMPLE_BITS >= madc_pkg::SAMPLE_W) ? {madc_pkg::SAMPLE_W{1'b1}}
                                            : madc_pkg::SAMPLE_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [madc_pkg::CHAN_W:0]   CHAN_COUNT = (madc_pkg::CHAN_W + 1)'(NUM_CHANNELS);
    localparam logic [madc_pkg::CHAN_W-1:0] LAST_CHAN  = madc_pkg::CHAN_W'(NUM_CHANNELS - 1);
    localparam logic [madc_pkg::SCAN_W-1:0] SCAN_LIMIT = madc_pkg::SCAN_W'(AVG_SCANS);

    madc_pkg::cfg_t                    cfg_reg;
    logic [NUM_CHANNELS-1:0]           dig_mask_reg;
    logic [madc_pkg::SCAN_W-1:0]       scan_cnt_reg, scan_cnt_next;

    logic                              accept;
    logic                              item_go;
    logic                              discard;
    logic                              last_chan;
    madc_pkg::item_t                   item;

    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic [madc_pkg::ENTRY_W-1:0]      mem_wdata;
    logic [madc_pkg::ENTRY_W-1:0]      mem_rdata;

    logic                              res_valid;
    madc_pkg::result_t                 res;
    madc_pkg::result_t                 out_res;
    logic                              buf_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_ticks   <= madc_pkg::UP_TICKS_RST;
            cfg_reg.down_ticks <= madc_pkg::DOWN_TICKS_RST;
            cfg_reg.threshold  <= madc_pkg::THRESHOLD_RST;
            cfg_reg.hysteresis <= madc_pkg::HYSTERESIS_RST;
            dig_mask_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                madc_pkg::REG_UP_TICKS:   cfg_reg.up_ticks   <= cfg_data[madc_pkg::TICK_W-1:0];
                madc_pkg::REG_DOWN_TICKS: cfg_reg.down_ticks <= cfg_data[madc_pkg::TICK_W-1:0];
                madc_pkg::REG_THRESHOLD:  cfg_reg.threshold  <= cfg_data[madc_pkg::LEVEL_W-1:0];
                madc_pkg::REG_HYSTERESIS: cfg_reg.hysteresis <= cfg_data[madc_pkg::LEVEL_W-1:0];
                madc_pkg::REG_DIG_MASK:   dig_mask_reg       <= cfg_data[NUM_CHANNELS-1:0];
                default: ;
            endcase
        end
    end

    assign accept    = sample_valid && !sample_stall;
    assign item_go   = accept && ({1'b0, channel} < CHAN_COUNT);
    assign discard   = (scan_cnt_reg == SCAN_LIMIT);
    assign last_chan = (channel == LAST_CHAN);

    always_comb
    begin
        scan_cnt_next = scan_cnt_reg;
        if (item_go && last_chan)
        begin
            scan_cnt_next = discard ? '0 : scan_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
        end
        else
        begin
            scan_cnt_reg <= scan_cnt_next;
        end
    end

    assign item.channel = channel;
    assign item.sample  = sample & SAMPLE_MASK;
    assign item.discard = discard;

    madc_ram #(
        .WIDTH (madc_pkg::ENTRY_W),
        .DEPTH (NUM_CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (channel[AW-1:0]),
        .rdata (mem_rdata)
    );

    madc_chan_update #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .AVG_SCANS    (AVG_SCANS)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_go   (item_go),
        .item      (item),
        .cfg       (cfg_reg),
        .dig_mask  (dig_mask_reg),
        .rdata     (mem_rdata),
        .we        (mem_we),
        .waddr     (mem_waddr),
        .wdata     (mem_wdata),
        .res_valid (res_valid),
        .res       (res)
    );

    madc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .out_stall (result_stall),
        .out_valid (result_valid),
        .out_res   (out_res),
        .full      (buf_full)
    );

    assign sample_stall = buf_full;

    assign out_channel = out_res.channel;
    assign is_digital  = out_res.is_digital;
    assign avg_value   = out_res.avg;
    assign input_on    = out_res.on;

endmodule

FILE: hw/rtl/madc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module madc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/madc_chan_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madc_chan_update
// Read-modify-write stage: accumulates samples into the channel sums, forms
// the block average and runs the threshold debounce on digital channels.
// ----------------------------------------------------------------------------
module madc_chan_update #(
    parameter int NUM_CHANNELS = madc_pkg::NUM_CHANNELS_DEF,
    parameter int AVG_SCANS    = madc_pkg::AVG_SCANS_DEF,
    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_go,
    input  madc_pkg::item_t              item,
    input  madc_pkg::cfg_t               cfg,
    input  logic [NUM_CHANNELS-1:0]      dig_mask,
    input  logic [madc_pkg::ENTRY_W-1:0] rdata,
    output logic                         we,
    output logic [AW-1:0]                waddr,
    output logic [madc_pkg::ENTRY_W-1:0] wdata,
    output logic                         res_valid,
    output madc_pkg::result_t            res
);

    localparam int DIV_SHIFT = madc_pkg::SUM_W + 4;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = madc_pkg::SUM_W + RECIP_W;
    // rounded-up reciprocal, exact for every 16-bit sum and divisor up to 15
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << DIV_SHIFT) + AVG_SCANS - 1) / AVG_SCANS);

    logic                      s1_vld_reg;
    madc_pkg::item_t           s1_item_reg;
    logic [NUM_CHANNELS-1:0]   vld_reg, vld_next;
    logic                      fwd_vld_reg;
    logic [AW-1:0]             fwd_idx_reg;
    madc_pkg::chan_state_t     fwd_data_reg;

    logic [AW-1:0]             idx;
    madc_pkg::chan_state_t     cur;
    madc_pkg::chan_state_t     upd;
    logic [madc_pkg::SUM_W:0]  sum_ext;
    logic [PROD_W-1:0]         prod;
    logic [madc_pkg::SUM_W-1:0] quot;
    logic [madc_pkg::LEVEL_W-1:0] avg;
    logic [madc_pkg::LEVEL_W:0] hi_level;
    logic [madc_pkg::LEVEL_W:0] avg_plus_hyst;
    logic                      above;
    logic                      below;
    logic                      digital;

    assign idx = s1_item_reg.channel[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            fwd_vld_reg <= 1'b0;
            vld_reg     <= '0;
        end
        else
        begin
            s1_vld_reg  <= item_go;
            fwd_vld_reg <= s1_vld_reg;
            vld_reg     <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_go)
        begin
            s1_item_reg <= item;
        end
        fwd_idx_reg  <= idx;
        fwd_data_reg <= upd;
    end

    // entry written on the last edge is not yet in the read data
    always_comb
    begin
        if (fwd_vld_reg && (fwd_idx_reg == idx))
        begin
            cur = fwd_data_reg;
        end
        else if (vld_reg[idx])
        begin
            cur = madc_pkg::chan_state_t'(rdata);
        end
        else
        begin
            cur = '0;
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (s1_vld_reg)
        begin
            vld_next[idx] = 1'b1;
        end
    end

    assign sum_ext = {1'b0, cur.sum}
                   + {{(madc_pkg::SUM_W + 1 - madc_pkg::SAMPLE_W){1'b0}}, s1_item_reg.sample};

    assign prod = {{RECIP_W{1'b0}}, cur.sum} * {{madc_pkg::SUM_W{1'b0}}, RECIP};
    assign quot = prod[DIV_SHIFT +: madc_pkg::SUM_W];
    assign avg  = (quot > {{(madc_pkg::SUM_W - madc_pkg::LEVEL_W){1'b0}}, madc_pkg::AVG_MAX})
                ? madc_pkg::AVG_MAX : quot[madc_pkg::LEVEL_W-1:0];

    assign hi_level      = {1'b0, cfg.threshold} + {1'b0, cfg.hysteresis};
    assign avg_plus_hyst = {1'b0, avg} + {1'b0, cfg.hysteresis};
    assign above = {1'b0, avg} > hi_level;
    // avg < threshold - hysteresis, never true when the lower level is negative
    assign below = avg_plus_hyst < {1'b0, cfg.threshold};

    assign digital = dig_mask[idx];

    always_comb
    begin
        upd = cur;
        if (!s1_item_reg.discard)
        begin
            upd.sum = sum_ext[madc_pkg::SUM_W] ? madc_pkg::SUM_MAX
                                               : sum_ext[madc_pkg::SUM_W-1:0];
        end
        else
        begin
            upd.sum = '0;
            if (digital)
            begin
                if (above)
                begin
                    if (!cur.on)
                    begin
                        if (cur.up < cfg.up_ticks)
                        begin
                            upd.up = cur.up + 1'b1;
                        end
                        else
                        begin
                            upd.on   = 1'b1;
                            upd.down = '0;
                        end
                    end
                end
                else if (below)
                begin
                    if (cur.on)
                    begin
                        if (cur.down < cfg.down_ticks)
                        begin
                            upd.down = cur.down + 1'b1;
                        end
                        else
                        begin
                            upd.on = 1'b0;
                            upd.up = '0;
                        end
                    end
                end
            end
        end
    end

    assign we    = s1_vld_reg;
    assign waddr = idx;
    assign wdata = upd;

    assign res_valid      = s1_vld_reg && s1_item_reg.discard;
    assign res.channel    = s1_item_reg.channel;
    assign res.is_digital = digital;
    assign res.avg        = digital ? '0 : avg;
    assign res.on         = digital ? upd.on : 1'b0;

endmodule

FILE: hw/rtl/madc_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madc_out_buf
// Output register with a skid entry, so a result can wait behind a stalled output.
// ----------------------------------------------------------------------------
module madc_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  madc_pkg::result_t push_res,
    input  logic              out_stall,
    output logic              out_valid,
    output madc_pkg::result_t out_res,
    output logic              full
);

    logic              out_vld_reg;
    madc_pkg::result_t out_res_reg;
    logic              skid_vld_reg;
    madc_pkg::result_t skid_res_reg;
    logic              out_free;

    assign out_free = !out_vld_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg  <= skid_vld_reg || push;
            skid_vld_reg <= skid_vld_reg && push;
        end
        else if (push)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_res_reg  <= skid_vld_reg ? skid_res_reg : push_res;
            skid_res_reg <= push_res;
        end
        else if (push)
        begin
            skid_res_reg <= push_res;
        end
    end

    // leave room for the result that may still be in the update stage
    assign full      = skid_vld_reg || (out_vld_reg && out_stall && push);
    assign out_valid = out_vld_reg;
    assign out_res   = out_res_reg;

endmodule
